@@ rtl/prf_pkg.sv @@
// Shared types and constants for the paced frame relay.
package prf_pkg;

    // Field widths
    localparam int CPT_W = 13;
    localparam int OFS_W = 9;

    // Parameter defaults
    localparam int PENDING_DEPTH_DEF = 4096;
    localparam int MAX_BURST_DEF     = 16;

    // Frame store
    localparam int STORE_DEPTH = 257;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Item mode codes
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // Protocol bytes
    localparam logic [7:0] STX_BYTE   = 8'h02;
    localparam logic [7:0] CANCEL_LEN = 8'h06;
    localparam logic [7:0] CANCEL_CMD = 8'h40;
    localparam logic [7:0] ETX_BYTE   = 8'h03;
    localparam logic [7:0] ST_ILLEGAL = 8'h32;
    localparam logic [7:0] ST_NOJOB   = 8'h30;
    localparam logic [7:0] LEN_MIN    = 8'h02;

    // Byte offsets inside the cancel status frame
    localparam logic [OFS_W-1:0] OFS_LEN    = 9'd1;
    localparam logic [OFS_W-1:0] OFS_CMD    = 9'd2;
    localparam logic [OFS_W-1:0] OFS_STATUS = 9'd5;
    localparam logic [OFS_W-1:0] OFS_ETX    = 9'd6;
    localparam logic [OFS_W-1:0] OFS_CHECK  = 9'd7;
    localparam logic [OFS_W-1:0] CANCEL_TGT = 9'd8;
    localparam logic [OFS_W-1:0] MIN_TGT    = 9'd4;

    localparam logic [CPT_W-1:0] CREDIT_RESET = 13'd983;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       last;
    } t_out_item;

    // Decoded transaction from the input channel
    typedef struct packed {
        logic byte_go;
        logic tick_go;
        logic flush;
    } t_cmd;

    // Byte headed for the pending queue; first marks the start of a unit
    typedef struct packed {
        logic             valid;
        logic             first;
        logic [OFS_W-1:0] len;
        logic [7:0]       data;
    } t_enq;

    typedef enum logic [1:0] {
        PH_HEAD,
        PH_LEN,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_STX2,
        FR_COPY
    } t_fr_state;

    typedef enum logic [1:0] {
        Q_IDLE,
        Q_RD,
        Q_LD
    } t_q_state;

endpackage

@@ rtl/prf_framer.sv @@
// Unit former: splits reader bytes into units, collects frames and copies them out.
module prf_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prf_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_byte,
    output prf_pkg::t_enq       o_enq,
    output logic                o_busy
);
    import prf_pkg::*;

    t_fr_state        r_state, n_state;
    t_phase           r_phase, n_phase;
    logic [OFS_W-1:0] r_target, n_target;
    logic [OFS_W-1:0] r_fill, n_fill;
    logic [OFS_W-1:0] r_idx, n_idx;
    logic [OFS_W-1:0] r_rd_off, n_rd_off;
    logic             r_rd_vld, n_rd_vld;
    logic             r_cmd_ok, n_cmd_ok;
    logic             r_st_ok, n_st_ok;
    logic             r_etx_ok, n_etx_ok;
    logic [7:0]       r_hold, n_hold;
    logic [7:0]       r_rd_data;

    logic [7:0]          mem [STORE_DEPTH];
    logic                w_we;
    logic [STORE_AW-1:0] w_waddr;
    logic                w_re;
    logic                w_match;
    logic                w_body_done;
    logic [7:0]          w_out_byte;

    assign o_busy      = (r_state != FR_IDLE);
    assign w_body_done = ((r_fill + 9'd1) >= r_target);
    assign w_match     = (r_target == CANCEL_TGT) && r_cmd_ok && r_st_ok && r_etx_ok;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE: begin
                if (i_cmd.byte_go) begin
                    if (r_phase == PH_LEN && i_byte < LEN_MIN) begin
                        n_state = FR_STX2;
                    end else if (r_phase == PH_BODY && w_body_done) begin
                        n_state = FR_COPY;
                    end
                end
            end
            FR_STX2: n_state = FR_IDLE;
            FR_COPY: begin
                if (r_rd_vld && r_rd_off == r_target - 9'd1) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
        if (i_cmd.flush) begin
            n_state = FR_IDLE;
        end
    end

    // Rewrite the cancel status frame on its way out
    always_comb begin
        w_out_byte = r_rd_data;
        if (w_match && r_rd_off == OFS_STATUS) begin
            w_out_byte = ST_NOJOB;
        end else if (w_match && r_rd_off == OFS_CHECK) begin
            w_out_byte = r_rd_data ^ (ST_ILLEGAL ^ ST_NOJOB);
        end
    end

    // Datapath and outputs
    always_comb begin
        n_phase  = r_phase;
        n_target = r_target;
        n_fill   = r_fill;
        n_idx    = r_idx;
        n_rd_off = r_rd_off;
        n_rd_vld = 1'b0;
        n_cmd_ok = r_cmd_ok;
        n_st_ok  = r_st_ok;
        n_etx_ok = r_etx_ok;
        n_hold   = r_hold;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_re     = 1'b0;
        o_enq    = '0;
        unique case (r_state)
            FR_IDLE: begin
                if (i_cmd.byte_go) begin
                    unique case (r_phase)
                        PH_HEAD: begin
                            if (i_byte != STX_BYTE) begin
                                o_enq = '{valid: 1'b1, first: 1'b1, len: 9'd1, data: i_byte};
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = '0;
                                n_fill  = 9'd1;
                                n_phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            if (i_byte < LEN_MIN) begin
                                // STX goes alone, the short length byte follows as its own unit
                                o_enq = '{valid: 1'b1, first: 1'b1, len: 9'd1, data: STX_BYTE};
                                n_hold  = i_byte;
                                n_phase = PH_HEAD;
                                n_fill  = '0;
                            end else begin
                                w_we     = 1'b1;
                                w_waddr  = OFS_LEN;
                                n_target = {1'b0, i_byte} + 9'd2;
                                n_fill   = 9'd2;
                                n_phase  = PH_BODY;
                            end
                        end
                        PH_BODY: begin
                            w_we    = 1'b1;
                            w_waddr = r_fill;
                            if (r_fill == OFS_CMD) n_cmd_ok = (i_byte == CANCEL_CMD);
                            if (r_fill == OFS_STATUS) n_st_ok = (i_byte == ST_ILLEGAL);
                            if (r_fill == OFS_ETX) n_etx_ok = (i_byte == ETX_BYTE);
                            n_fill = r_fill + 9'd1;
                            if (w_body_done) begin
                                n_idx   = '0;
                                n_fill  = '0;
                                n_phase = PH_HEAD;
                            end
                        end
                        default: n_phase = PH_HEAD;
                    endcase
                end
            end
            FR_STX2: begin
                o_enq = '{valid: 1'b1, first: 1'b1, len: 9'd1, data: r_hold};
            end
            FR_COPY: begin
                if (r_idx < r_target) begin
                    w_re     = 1'b1;
                    n_idx    = r_idx + 9'd1;
                    n_rd_vld = 1'b1;
                    n_rd_off = r_idx;
                end
                if (r_rd_vld) begin
                    o_enq = '{valid: 1'b1, first: (r_rd_off == '0), len: r_target,
                              data: w_out_byte};
                    if (r_rd_off == r_target - 9'd1) begin
                        n_target = '0;
                    end
                end
            end
            default: ;
        endcase
        if (i_cmd.flush) begin
            n_phase  = PH_HEAD;
            n_target = '0;
            n_fill   = '0;
            n_rd_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= FR_IDLE;
            r_phase  <= PH_HEAD;
            r_target <= '0;
            r_fill   <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_target <= n_target;
            r_fill   <= n_fill;
            r_idx    <= n_idx;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_off <= n_rd_off;
        r_cmd_ok <= n_cmd_ok;
        r_st_ok  <= n_st_ok;
        r_etx_ok <= n_etx_ok;
        r_hold   <= n_hold;
    end

    // Frame store
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= i_byte;
        end
        if (w_re) begin
            r_rd_data <= mem[r_idx];
        end
    end

`ifndef SYNTHESIS
    a_copy_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FR_COPY) |-> (r_target >= MIN_TGT))
        else $error("copy running on a frame shorter than four bytes");
    a_copy_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FR_COPY) |-> (r_idx <= r_target))
        else $error("frame copy read past the frame end");
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_fill < r_target))
        else $error("frame fill reached target without finishing");
    a_copy_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == FR_IDLE && i_cmd.byte_go && r_phase == PH_BODY && w_body_done)
        |=> (r_idx == '0 && !r_rd_vld))
        else $error("frame copy did not start at offset zero");
`endif

endmodule

@@ rtl/prf_queue.sv @@
// Pending byte queue with credit pacing and the output register.
module prf_queue #(
    parameter int PENDING_DEPTH = prf_pkg::PENDING_DEPTH_DEF,
    parameter int MAX_BURST     = prf_pkg::MAX_BURST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  prf_pkg::t_cmd               i_cmd,
    input  prf_pkg::t_enq               i_enq,
    input  logic                        i_cfg_we,
    input  logic [prf_pkg::CPT_W-1:0]   i_cfg_wdata,
    output logic                        o_busy,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output prf_pkg::t_out_item          o_out_item
);
    import prf_pkg::*;

    localparam int AW    = $clog2(PENDING_DEPTH);
    localparam int CW    = $clog2(PENDING_DEPTH + 1);
    localparam int CW1   = CW + 1;
    localparam int LIMIT = MAX_BURST * 256;
    localparam int CRW   = $clog2(LIMIT + 1);
    localparam int SUMW  = ((CRW > CPT_W) ? CRW : CPT_W) + 1;
    localparam int BW    = $clog2(MAX_BURST + 1);

    t_q_state        r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic [CRW-1:0]  r_credit, n_credit;
    logic [CPT_W-1:0] r_cpt;
    logic [BW-1:0]   r_left, n_left;
    logic            r_unit_ok, n_unit_ok;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out;
    logic [7:0]      r_rd_data;

    logic [7:0]      mem [PENDING_DEPTH];

    logic [SUMW-1:0] w_sum;
    logic [CRW-1:0]  w_sat;
    logic [CW-1:0]   w_whole;
    logic [CW-1:0]   w_rel_c;
    logic [BW-1:0]   w_rel;
    logic            w_room_ok;
    logic            w_wr;
    logic            w_take;
    logic            w_free;
    logic            w_re;

    assign o_busy      = (r_state != Q_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_take      = r_out_valid && i_out_ready;
    assign w_free      = !r_out_valid || w_take;
    assign w_re        = (r_state == Q_RD) && w_free;

    // Credit for this tick, saturated, and whole bytes to release
    assign w_sum   = SUMW'(r_credit) + SUMW'(r_cpt);
    assign w_sat   = (w_sum > SUMW'(LIMIT)) ? CRW'(LIMIT) : w_sum[CRW-1:0];
    assign w_whole = CW'(w_sat[CRW-1:8]);
    assign w_rel_c = (r_count < w_whole) ? r_count : w_whole;
    assign w_rel   = w_rel_c[BW-1:0];

    // A unit goes in whole or not at all
    assign w_room_ok = (CW1'(r_count) + CW1'(i_enq.len)) <= CW1'(PENDING_DEPTH);
    assign w_wr      = i_enq.valid && (i_enq.first ? w_room_ok : r_unit_ok);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            Q_IDLE: begin
                if (i_cmd.tick_go && r_count != '0 && w_rel != '0) begin
                    n_state = Q_RD;
                end
            end
            Q_RD: begin
                if (w_free) begin
                    n_state = Q_LD;
                end
            end
            Q_LD: n_state = (r_left == '0) ? Q_IDLE : Q_RD;
            default: n_state = Q_IDLE;
        endcase
        if (i_cmd.flush) begin
            n_state = Q_IDLE;
        end
    end

    // Datapath
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_credit    = r_credit;
        n_left      = r_left;
        n_unit_ok   = r_unit_ok;
        n_out_valid = r_out_valid && !w_take;
        if (i_enq.valid && i_enq.first) begin
            n_unit_ok = w_room_ok;
        end
        if (w_wr) begin
            n_tail  = (r_tail == AW'(PENDING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
        unique case (r_state)
            Q_IDLE: begin
                if (i_cmd.tick_go) begin
                    if (r_count == '0) begin
                        n_credit = '0;
                    end else begin
                        n_credit = w_sat - (CRW'(w_rel) << 8);
                        n_count  = r_count - CW'(w_rel);
                        n_left   = w_rel;
                    end
                end
            end
            Q_RD: begin
                if (w_free) begin
                    n_head = (r_head == AW'(PENDING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_left = r_left - 1'b1;
                end
            end
            Q_LD: n_out_valid = 1'b1;
            default: ;
        endcase
        // Reconnect: drop everything queued, keep a byte already presented
        if (i_cmd.flush) begin
            n_head    = '0;
            n_tail    = '0;
            n_count   = '0;
            n_credit  = '0;
            n_unit_ok = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= Q_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_credit    <= '0;
            r_left      <= '0;
            r_unit_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cpt       <= CREDIT_RESET;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_credit    <= n_credit;
            r_left      <= n_left;
            r_unit_ok   <= n_unit_ok;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_cpt <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == Q_LD) begin
            r_out.byte_out <= r_rd_data;
            r_out.last     <= (r_left == '0);
        end
    end

    // Pending memory
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            mem[r_tail] <= i_enq.data;
        end
        if (w_re) begin
            r_rd_data <= mem[r_head];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(PENDING_DEPTH))
        else $error("pending count above queue depth");
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRW'(LIMIT))
        else $error("credit above burst limit");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == Q_LD) |-> !r_out_valid)
        else $error("output register loaded while still holding a byte");
    a_enq_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_enq.valid |-> (r_state == Q_IDLE))
        else $error("enqueue during release");
`endif

endmodule

@@ rtl/paced_frame_relay_core.sv @@
// Top level of the paced frame relay: input decode and the two units.
//
// Input channel (valid/ready) carries one transaction per item: mode 0 is a
// reader byte, mode 1 a time tick, mode 2 a reconnect flush, mode 3 is
// ignored. Output channel (valid/ready) carries released bytes, oldest
// first, with last set on the final byte released by one tick.
// A plain byte or a frame body byte leaves the input ready. The byte that
// completes a frame of N bytes starts a copy from the frame store into the
// pending memory, one byte per cycle; the input is not ready until it ends.
// STX followed by a short length is passed on as two units, STX first. A
// tick releases up to MAX_BURST bytes, each through a pending memory read,
// then an output register load. A stall holds the presented byte and the
// release waits for it.
// A new transaction is accepted while the last released byte still waits.
// The credit register takes i_cfg_wdata on i_cfg_we outside reset.
// Reset returns all control state to empty and the credit register to 983;
// the memories need no clearing pass.
module paced_frame_relay_core #(
    parameter int PENDING_DEPTH = prf_pkg::PENDING_DEPTH_DEF,
    parameter int MAX_BURST     = prf_pkg::MAX_BURST_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  prf_pkg::t_in_item           i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output prf_pkg::t_out_item          o_out_item,
    input  logic                        i_cfg_we,
    input  logic [prf_pkg::CPT_W-1:0]   i_cfg_wdata
);
    import prf_pkg::*;

    logic  w_acc;
    logic  w_fr_busy;
    logic  w_q_busy;
    t_cmd  w_cmd;
    t_enq  w_enq;

    assign o_in_ready    = !w_fr_busy && !w_q_busy;
    assign w_acc         = i_in_valid && o_in_ready;
    assign w_cmd.byte_go = w_acc && (i_in_item.mode == MODE_BYTE);
    assign w_cmd.tick_go = w_acc && (i_in_item.mode == MODE_TICK);
    assign w_cmd.flush   = w_acc && (i_in_item.mode == MODE_FLUSH);

    prf_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_byte  (i_in_item.data_byte),
        .o_enq   (w_enq),
        .o_busy  (w_fr_busy)
    );

    prf_queue #(
        .PENDING_DEPTH (PENDING_DEPTH),
        .MAX_BURST     (MAX_BURST)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_enq       (w_enq),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_busy      (w_q_busy),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
